// File: rtl/core/dht_sensor_frame_decoder_assert.svh
// -----------------------------------------------------------------------------
// DHT frame decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// -----------------------------------------------------------------------------
`ifndef DHT_SENSOR_FRAME_DECODER_ASSERT_SVH
`define DHT_SENSOR_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define DHTFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dht frame decoder check failed");

// next-cycle implication
`define DHTFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dht frame decoder check failed");

`endif

// File: rtl/core/dhtfd_pkg.sv
// -----------------------------------------------------------------------------
// DHT frame decoder package
// Status and model codes, register indexes, reset values, frame constants.
// -----------------------------------------------------------------------------
package dhtfd_pkg;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_RESPONSE = 2'd1,
        ST_CHECKSUM    = 2'd2,
        ST_BAD_MODEL   = 2'd3
    } t_status;

    localparam logic [2:0] MODEL_DHT11 = 3'd0;
    localparam logic [2:0] MODEL_DHT12 = 3'd1;
    localparam logic [2:0] MODEL_DHT21 = 3'd2;
    localparam logic [2:0] MODEL_DHT22 = 3'd3;

    localparam logic REG_SENSOR_MODEL  = 1'b0;
    localparam logic REG_TIMEOUT_COUNT = 1'b1;

    localparam logic [2:0]  MODEL_RESET   = MODEL_DHT22;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3200;

    localparam logic [5:0]  FRAME_LEN  = 6'd40;
    localparam logic [7:0]  LOW7_MASK  = 8'h7F;
    localparam logic [16:0] HUM_OFFSET = 17'd1;

    localparam logic REQ_START = 1'b0;

endpackage

// File: rtl/core/dht_sensor_frame_decoder.sv
// -----------------------------------------------------------------------------
// DHT sensor frame decoder
// Decodes start and bit beats of a single-wire DHT frame into humidity and
// temperature results.
// -----------------------------------------------------------------------------
// Path from input beat to result: input register, then result register.
// Throughput: one input beat per cycle when not stalled; the bit decision is
// made at the input register; frame shift, checksum and conversion sit in one stage.
// Reset (i_rst_n low, synchronous): frame state and handshake flags clear,
// sensor_model = DHT22, timeout_count = 3200.
module dht_sensor_frame_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic                  i_ack_seen,
    input  logic [15:0]           i_low_width,
    input  logic [15:0]           i_high_width,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [16:0]           o_humidity_tenths,
    output logic signed [15:0]    o_temperature_tenths
);
    import dhtfd_pkg::*;

    // configuration
    logic [2:0]  r_model;
    logic [15:0] r_timeout;

    // input register
    logic        r_in_valid;
    logic        r_req;
    logic        r_ack;
    logic        r_bit;

    // frame state
    logic [39:0] r_frame, n_frame;
    logic [5:0]  r_count, n_count;
    logic        r_in_frame, n_in_frame;

    // result register
    logic        r_out_valid;
    t_status     r_status;
    logic [16:0] r_hum;
    logic [15:0] r_temp;

    logic        cfg_write;
    logic        accept_in;
    logic        out_free;
    logic        stage_go;
    logic        bit_in;
    logic [15:0] rem_low;
    logic [15:0] rem_high;
    logic        res_valid;
    t_status     res_status;
    logic [16:0] res_hum;
    logic [15:0] res_temp;
    logic [39:0] shifted;
    logic [5:0]  cnt_inc;
    logic [7:0]  d0, d1, d2, d3, d4;
    logic [7:0]  sum8;
    logic [11:0] d0x10, d2x10;
    logic [16:0] hum;
    logic [15:0] mag;
    logic        neg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model   <= MODEL_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_SENSOR_MODEL:  r_model   <= pwdata[2:0];
                REG_TIMEOUT_COUNT: r_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            case (paddr[2])
                REG_SENSOR_MODEL:  prdata = {29'd0, r_model};
                REG_TIMEOUT_COUNT: prdata = {16'd0, r_timeout};
                default:           prdata = 32'd0;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign stage_go   = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept_in  = i_in_valid && !o_in_stall;

    // bit decision from remaining counts, saturated at zero
    always_comb begin
        rem_low  = (i_low_width  >= r_timeout) ? 16'd0 : (r_timeout - i_low_width);
        rem_high = (i_high_width >= r_timeout) ? 16'd0 : (r_timeout - i_high_width);
        bit_in   = (rem_low > rem_high);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (stage_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_req <= i_req_type;
            r_ack <= i_ack_seen;
            r_bit <= bit_in;
        end
    end

    // ---------------- frame stage ----------------
    assign shifted = {r_frame[38:0], r_bit};
    assign cnt_inc = r_count + 6'd1;
    assign d0      = shifted[39:32];
    assign d1      = shifted[31:24];
    assign d2      = shifted[23:16];
    assign d3      = shifted[15:8];
    assign d4      = shifted[7:0];
    assign sum8    = d0 + d1 + d2 + d3;
    assign d0x10   = {1'b0, d0, 3'b000} + {3'b000, d0, 1'b0};
    assign d2x10   = {1'b0, d2, 3'b000} + {3'b000, d2, 1'b0};

    // conversion per sensor model
    always_comb begin
        hum = 17'd0;
        mag = 16'd0;
        neg = 1'b0;
        case (r_model)
            MODEL_DHT11: begin
                hum = 17'(d0x10) + 17'(d1);
                mag = 16'(d2x10) + 16'(d3);
            end
            MODEL_DHT12: begin
                hum = 17'(d0x10) + 17'(d1);
                mag = 16'(d2x10) + 16'(d3 & LOW7_MASK);
                neg = d3[7];
            end
            MODEL_DHT21, MODEL_DHT22: begin
                hum = {1'b0, d0, d1};
                mag = {1'b0, d2[6:0], d3};
                neg = d2[7];
            end
            default: ;
        endcase
    end

    always_comb begin
        n_frame    = r_frame;
        n_count    = r_count;
        n_in_frame = r_in_frame;
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_hum    = 17'd0;
        res_temp   = 16'd0;
        if (stage_go) begin
            if (r_req == REQ_START) begin
                n_frame    = 40'd0;
                n_count    = 6'd0;
                n_in_frame = r_ack;
                if (!r_ack) begin
                    res_valid  = 1'b1;
                    res_status = ST_NO_RESPONSE;
                end
            end else if (r_in_frame) begin
                n_frame = shifted;
                if (cnt_inc == FRAME_LEN) begin
                    n_count    = 6'd0;
                    n_in_frame = 1'b0;
                    res_valid  = 1'b1;
                    if (sum8 != d4) begin
                        res_status = ST_CHECKSUM;
                    end else if (r_model > MODEL_DHT22) begin
                        res_status = ST_BAD_MODEL;
                    end else begin
                        res_status = ST_OK;
                        res_hum    = hum + HUM_OFFSET;
                        res_temp   = neg ? (16'd0 - mag) : mag;
                    end
                end else begin
                    n_count = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= 40'd0;
            r_count    <= 6'd0;
            r_in_frame <= 1'b0;
        end else begin
            r_frame    <= n_frame;
            r_count    <= n_count;
            r_in_frame <= n_in_frame;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_status <= res_status;
            r_hum    <= res_hum;
            r_temp   <= res_temp;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_status;
    assign o_humidity_tenths    = r_hum;
    assign o_temperature_tenths = r_temp;

endmodule

// File: rtl/core/dht_sensor_frame_decoder_checker.sv
// -----------------------------------------------------------------------------
// DHT frame decoder checker
// Port-level checks on the decoder, bound into the decoder module.
// -----------------------------------------------------------------------------
`include "dht_sensor_frame_decoder_assert.svh"

module dht_sensor_frame_decoder_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  pready,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic [1:0]            o_status,
    input  logic [16:0]           o_humidity_tenths,
    input  logic signed [15:0]    o_temperature_tenths
);
    import dhtfd_pkg::*;

    logic held;
    logic bad_status;
    logic good_status;

    assign held        = o_out_valid && i_out_stall;
    assign bad_status  = o_out_valid && (o_status != ST_OK);
    assign good_status = o_out_valid && (o_status == ST_OK);

    // a stalled beat stays up and unchanged
    `DHTFD_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, held, o_out_valid)
    `DHTFD_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, held, $stable(o_status) && $stable(o_humidity_tenths) && $stable(o_temperature_tenths))

    // error results carry zero readings
    `DHTFD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, bad_status, (o_humidity_tenths == 17'd0) && (o_temperature_tenths == 16'sd0))

    // the humidity offset makes a good reading nonzero
    `DHTFD_ASSERT_NOW(a_ok_hum, i_clk, i_rst_n, good_status, o_humidity_tenths != 17'd0)

    `DHTFD_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind dht_sensor_frame_decoder dht_sensor_frame_decoder_checker u_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .pready               (pready),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_status             (o_status),
    .o_humidity_tenths    (o_humidity_tenths),
    .o_temperature_tenths (o_temperature_tenths)
);

// File: tb/dht_frame_scoreboard_pkg.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// DHT frame decoder scoreboard
// Predicts readings from accepted beats and checks the decoder output in order.
// -----------------------------------------------------------------------------
package dht_frame_scoreboard_pkg;
    import dhtfd_pkg::*;

    localparam int DECIMAL_SCALE = 10;

    typedef struct {
        t_status            status;
        logic [16:0]        humidity;
        logic signed [15:0] temperature;
    } t_reading;

    class dht_frame_scoreboard;
        t_reading    pending_q[$];
        logic [2:0]  model;
        logic [15:0] timeout;
        logic [39:0] shift_bits;
        logic [5:0]  bits_seen;
        bit          frame_open;
        int          mismatches;
        int          beats_decoded;
        int          readings_due;
        int          readings_seen;
        int          status_hits[4];

        function new();
            model         = MODEL_RESET;
            timeout       = TIMEOUT_RESET;
            shift_bits    = '0;
            bits_seen     = '0;
            frame_open    = 1'b0;
            mismatches    = 0;
            beats_decoded = 0;
            readings_due  = 0;
            readings_seen = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_SENSOR_MODEL) begin
                model = value[2:0];
            end else begin
                timeout = value[15:0];
            end
        endfunction

        // counts left before the timeout, clamped at zero
        function logic [15:0] slack(logic [15:0] width);
            return (width >= timeout) ? 16'd0 : timeout - width;
        endfunction

        function void push_reading(t_status st, logic [16:0] hum, logic signed [15:0] temp);
            t_reading r;
            r.status      = st;
            r.humidity    = hum;
            r.temperature = temp;
            pending_q.push_back(r);
            readings_due++;
        endfunction

        function void close_frame();
            logic [7:0] d0, d1, d2, d3, d4, sum;
            int         hum;
            int         mag;
            bit         neg;
            {d0, d1, d2, d3, d4} = shift_bits;
            sum = d0 + d1 + d2 + d3;
            if (sum != d4) begin
                push_reading(ST_CHECKSUM, '0, '0);
                return;
            end
            case (model)
                MODEL_DHT11: begin
                    hum = int'(d0) * DECIMAL_SCALE + int'(d1);
                    mag = int'(d2) * DECIMAL_SCALE + int'(d3);
                    neg = 1'b0;
                end
                MODEL_DHT12: begin
                    hum = int'(d0) * DECIMAL_SCALE + int'(d1);
                    mag = int'(d2) * DECIMAL_SCALE + int'(d3 & LOW7_MASK);
                    neg = d3[7];
                end
                MODEL_DHT21, MODEL_DHT22: begin
                    hum = int'({d0, d1});
                    mag = int'({d2[6:0], d3});
                    neg = d2[7];
                end
                default: begin
                    push_reading(ST_BAD_MODEL, '0, '0);
                    return;
                end
            endcase
            // a negative zero comes out as plain zero
            push_reading(ST_OK, 17'(hum + int'(HUM_OFFSET)), neg ? 16'(-mag) : 16'(mag));
        endfunction

        function void note_beat(logic req, logic ack, logic [15:0] lw, logic [15:0] hw);
            if (req == REQ_START) begin
                beats_decoded++;
                shift_bits = '0;
                bits_seen  = '0;
                frame_open = ack;
                if (!ack) push_reading(ST_NO_RESPONSE, '0, '0);
                return;
            end
            if (!frame_open) return;
            beats_decoded++;
            shift_bits = {shift_bits[38:0], slack(lw) > slack(hw)};
            bits_seen++;
            if (bits_seen == FRAME_LEN) begin
                frame_open = 1'b0;
                bits_seen  = '0;
                close_frame();
            end
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task check_reading(logic [1:0] st, logic [16:0] hum, logic signed [15:0] temp);
            t_reading want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected reading status=%0d hum=%0d temp=%0d",
                                 st, hum, temp));
                return;
            end
            want = pending_q.pop_front();
            readings_seen++;
            status_hits[want.status]++;
            if (st !== want.status)
                report($sformatf("status %0d, want %0d", st, want.status));
            if (hum !== want.humidity)
                report($sformatf("humidity %0d, want %0d", hum, want.humidity));
            if (temp !== want.temperature)
                report($sformatf("temperature %0d, want %0d", temp, want.temperature));
        endtask
    endclass

endpackage

// File: tb/dht_sensor_frame_decoder_test.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// DHT sensor frame decoder testbench
// Drives start and bit beats through phases of sensor model and timeout
// settings, with random idles and stalls on both channels, and checks every
// reading against an in-order prediction.
// -----------------------------------------------------------------------------
module dht_sensor_frame_decoder_test;
    import dhtfd_pkg::*;
    import dht_frame_scoreboard_pkg::*;

    localparam logic       REQ_BIT       = ~REQ_START;
    localparam logic [2:0] MODEL_UNKNOWN = 3'd4;
    localparam logic [2:0] MODEL_TOP     = 3'd7;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 120;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 4;
    localparam int QUIET_LIMIT   = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_req_type;
    logic               i_ack_seen;
    logic [15:0]        i_low_width;
    logic [15:0]        i_high_width;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [16:0]        o_humidity_tenths;
    logic signed [15:0] o_temperature_tenths;

    dht_frame_scoreboard sb;
    int          idle_pct      = 12;
    int          hold_request  = 0;
    int          quiet_cycles  = 0;
    int          config_writes = 0;
    int          carry_bits    = 0;
    logic [39:0] carry_frame   = '0;

    dht_sensor_frame_decoder uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_req_type           (i_req_type),
        .i_ack_seen           (i_ack_seen),
        .i_low_width          (i_low_width),
        .i_high_width         (i_high_width),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_humidity_tenths    (o_humidity_tenths),
        .o_temperature_tenths (o_temperature_tenths)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit idle_roll();
        return $urandom_range(0, 99) < idle_pct;
    endfunction

    function automatic logic [39:0] random_frame(bit good_sum);
        logic [7:0] d0, d1, d2, d3, d4;
        d0 = 8'($urandom);
        d1 = 8'($urandom);
        d2 = 8'($urandom);
        d3 = 8'($urandom);
        d4 = good_sum ? 8'(d0 + d1 + d2 + d3) : 8'($urandom);
        return {d0, d1, d2, d3, d4};
    endfunction

    // full scale, all zero, negative zeros for both sign layouts, bad sum, a plain reading
    function automatic logic [39:0] corner_frame(int idx);
        case (idx % 6)
            0:       return 40'hFF_FF_FF_FF_FC;
            1:       return 40'h00_00_00_00_00;
            2:       return 40'h00_00_80_00_80;
            3:       return 40'h00_00_00_80_80;
            4:       return 40'h01_02_03_04_00;
            default: return 40'h02_8C_01_5F_EE;
        endcase
    endfunction

    task automatic send_beat(logic req, logic ack, logic [15:0] lw, logic [15:0] hw);
        @(negedge i_clk);
        while (idle_roll()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_ack_seen   <= ack;
        i_low_width  <= lw;
        i_high_width <= hw;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_beat(req, ack, lw, hw);
    endtask

    task automatic send_start(logic ack);
        send_beat(REQ_START, ack, 16'($urandom), 16'($urandom));
    endtask

    // mostly pick pulse widths that decode to the wanted bit under the current timeout
    task automatic send_data_bit(bit value);
        logic [15:0] lw, hw;
        int          t;
        t = int'(sb.timeout);
        if (t == 0 || $urandom_range(0, 99) < 8) begin
            lw = 16'($urandom);
            hw = 16'($urandom);
        end else if (value) begin
            lw = 16'($urandom_range(0, t - 1));
            hw = 16'($urandom_range(int'(lw) + 1, 65535));
        end else begin
            hw = 16'($urandom);
            lw = 16'($urandom_range(int'(hw), 65535));
        end
        send_beat(REQ_BIT, 1'($urandom), lw, hw);
    endtask

    task automatic send_frame_bits(logic [39:0] bits, int first, int last);
        for (int i = first; i < last; i++) send_data_bit(bits[39 - i]);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        logic [31:0] mask;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, value);
        config_writes++;
        // read it back
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        mask = (idx == REG_SENSOR_MODEL) ? 32'h7 : 32'hFFFF;
        if ((prdata & mask) !== (value & mask))
            sb.report($sformatf("register %0d reads %0h, want %0h", idx, prdata & mask,
                                value & mask));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(int phase);
        int base;
        int pick;
        int cut;
        bit ack;
        base = sb.beats_decoded;
        if (carry_bits > 0) begin
            // frame opened before the register writes finishes under the new setting
            send_frame_bits(carry_frame, carry_bits, 40);
            carry_bits = 0;
        end
        send_start(1'b1);
        send_frame_bits(corner_frame(phase), 0, 40);
        if (phase == 2) begin
            hold_request = HOLD_CYCLES;
            repeat (12) send_start(1'b0);
        end
        while (sb.beats_decoded - base < PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_start(1'b1);
                send_frame_bits(random_frame($urandom_range(0, 99) < 85), 0, 40);
            end else if (pick < 77) begin
                send_start(1'b1);
                cut = $urandom_range(1, 39);
                send_frame_bits(random_frame(1'b1), 0, cut);
                ack = 1'($urandom);
                send_start(ack);
                if (ack) send_frame_bits(random_frame(1'b1), 0, 40);
            end else if (pick < 89) begin
                send_start(1'b0);
            end else if (!sb.frame_open) begin
                repeat ($urandom_range(1, 3))
                    send_beat(REQ_BIT, 1'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        if ($urandom_range(0, 1)) begin
            carry_frame = random_frame(1'b1);
            carry_bits  = $urandom_range(1, 39);
            send_start(1'b1);
            send_frame_bits(carry_frame, 0, carry_bits);
        end
        wait_idle();
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= idle_roll();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reading(o_status, o_humidity_tenths, o_temperature_tenths);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL dht_sensor_frame_decoder");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;
        sb           = new();
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_START;
        i_ack_seen   = 1'b0;
        i_low_width  = '0;
        i_high_width = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stray bits, no response, pulse extremes, restart and abort
        send_beat(REQ_BIT, 1'b1, 16'h0000, 16'hFFFF);
        send_beat(REQ_BIT, 1'b0, 16'hFFFF, 16'h0000);
        send_beat(REQ_START, 1'b0, 16'hFFFF, 16'hFFFF);
        send_beat(REQ_START, 1'b1, 16'h0000, 16'h0000);
        send_beat(REQ_BIT, 1'b0, 16'h0000, 16'hFFFF);
        send_beat(REQ_BIT, 1'b1, 16'hFFFF, 16'h0000);
        send_beat(REQ_BIT, 1'b0, TIMEOUT_RESET, TIMEOUT_RESET);
        send_beat(REQ_BIT, 1'b1, TIMEOUT_RESET - 16'd1, TIMEOUT_RESET);
        send_beat(REQ_BIT, 1'b0, TIMEOUT_RESET, TIMEOUT_RESET - 16'd1);
        send_beat(REQ_BIT, 1'b1, 16'h0000, 16'h0000);
        send_beat(REQ_START, 1'b1, 16'hFFFF, 16'h0000);
        send_beat(REQ_BIT, 1'b0, 16'h0001, 16'hFFFE);
        send_beat(REQ_BIT, 1'b1, 16'h8000, 16'h7FFF);
        send_beat(REQ_BIT, 1'b0, 16'h5555, 16'hAAAA);
        send_beat(REQ_START, 1'b0, 16'h0000, 16'hFFFF);
        send_beat(REQ_BIT, 1'b1, 16'h1234, 16'h4321);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_reg(REG_SENSOR_MODEL, 32'(MODEL_DHT11));
                    write_reg(REG_TIMEOUT_COUNT, 32'd1);
                end
                2: begin
                    write_reg(REG_SENSOR_MODEL, 32'(MODEL_DHT12));
                    write_reg(REG_TIMEOUT_COUNT, 32'hFFFF);
                end
                3: begin
                    write_reg(REG_SENSOR_MODEL, 32'(MODEL_DHT21));
                    write_reg(REG_TIMEOUT_COUNT, 32'd0);
                end
                4: begin
                    write_reg(REG_SENSOR_MODEL, 32'(MODEL_TOP));
                    write_reg(REG_TIMEOUT_COUNT, 32'(TIMEOUT_RESET));
                end
                5: begin
                    write_reg(REG_SENSOR_MODEL, 32'(MODEL_UNKNOWN));
                    write_reg(REG_TIMEOUT_COUNT, 32'd500);
                end
                6: begin
                    write_reg(REG_SENSOR_MODEL, 32'(MODEL_DHT22));
                    write_reg(REG_TIMEOUT_COUNT, $urandom_range(40, 4000));
                end
                default: begin
                    write_reg(REG_SENSOR_MODEL, $urandom_range(0, 7));
                    write_reg(REG_TIMEOUT_COUNT, $urandom_range(0, 65535));
                end
            endcase
            // one phase runs at full rate on both sides
            idle_pct = (phase == 5) ? 0 : 12;
            run_phase(phase);
        end
        idle_pct = 12;

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d decoded beats, %0d readings: %0d ok, %0d no response,",
                 sb.beats_decoded, sb.readings_seen, sb.status_hits[ST_OK],
                 sb.status_hits[ST_NO_RESPONSE]);
        $display("%0d checksum, %0d bad model; %0d register writes over %0d settings.",
                 sb.status_hits[ST_CHECKSUM], sb.status_hits[ST_BAD_MODEL],
                 config_writes, phase);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("PASS dht_sensor_frame_decoder");
        end else begin
            $display("FAIL dht_sensor_frame_decoder");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dhtfd_pkg.sv
rtl/core/dht_sensor_frame_decoder.sv
rtl/core/dht_sensor_frame_decoder_checker.sv
tb/dht_frame_scoreboard_pkg.sv
tb/dht_sensor_frame_decoder_test.sv
